### sv/base64_strict_decoder_top_assert.svh
// Assertion macros shared by the base64 strict decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BASE64_STRICT_DECODER_TOP_ASSERT_SVH
`define BASE64_STRICT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define B64SD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define B64SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/b64sd_pkg.sv
// Types and constants for the base64 strict decoder.
// No dependencies; imported by every module of the block.
package b64sd_pkg;

    localparam logic [7:0]  CHAR_PAD      = 8'h3D;
    localparam logic [15:0] MAX_OUT_RESET = 16'hFFFF;

    // Status codes reported on the final item
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_BAD_PAD  = 3'd2,
        ST_PARTIAL  = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_LEFTOVER = 3'd5
    } t_status;

    // Padding phase of the current group
    typedef enum logic [1:0] {
        PH_SYMBOLS  = 2'd0,
        PH_NEED_PAD = 2'd1,
        PH_DONE     = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_final;
        logic [2:0]  status;
        logic [15:0] byte_count;
    } t_out_item;

    // Character class from the lookup
    typedef struct packed {
        logic       is_white;
        logic       is_pad;
        logic       is_sym;
        logic [5:0] sym;
    } t_char_class;

    // Result of one step of the core
    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_step_res;

endpackage

### sv/b64sd_classify.sv
// Character classifier: whitespace, padding and base64 alphabet lookup.
// Depends on b64sd_pkg.
module b64sd_classify
    import b64sd_pkg::*;
(
    input  logic [7:0]  i_char_code,
    output t_char_class o_class
);

    // Alphabet lookup and character classes
    always_comb begin
        o_class.is_white = 1'b0;
        o_class.is_pad   = (i_char_code == CHAR_PAD);
        o_class.is_sym   = 1'b1;
        o_class.sym      = '0;
        unique case (i_char_code) inside
            [8'h41:8'h5A]: o_class.sym = 6'(i_char_code - 8'h41);
            [8'h61:8'h7A]: o_class.sym = 6'(i_char_code - 8'h61 + 8'd26);
            [8'h30:8'h39]: o_class.sym = 6'(i_char_code - 8'h30 + 8'd52);
            8'h2B:         o_class.sym = 6'd62;
            8'h2F:         o_class.sym = 6'd63;
            [8'h09:8'h0D], 8'h20: begin
                o_class.is_white = 1'b1;
                o_class.is_sym   = 1'b0;
            end
            default:       o_class.is_sym = 1'b0;
        endcase
    end

endmodule

### sv/b64sd_core.sv
// Decoder state and single-step update logic for one item.
// Depends on b64sd_pkg and the assertion macro header.
`include "base64_strict_decoder_top_assert.svh"

module b64sd_core
    import b64sd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  t_in_item    i_item,
    input  t_char_class i_class,
    input  logic [15:0] i_max_out,
    output t_step_res   o_res
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [1:0]            r_group_pos, n_group_pos;
    t_phase                r_phase, n_phase;
    t_status               r_err, n_err;
    logic [7:0]            r_partial, n_partial;
    logic [COUNT_BITS-1:0] r_bytes_out, n_bytes_out;

    logic [7:0]            w_byte;
    logic [7:0]            w_partial_new;
    logic                  w_have_byte;
    logic                  w_ovf;
    logic [CW-1:0]         w_lim_max, w_lim_top, w_limit, w_cnt_ext, w_inc_ext;
    logic [COUNT_BITS-1:0] w_bytes_inc;
    logic                  w_active;
    t_status               w_end_status;

    // Byte assembly and capacity check
    always_comb begin
        w_have_byte = 1'b1;
        case (r_group_pos)
            2'd0: begin
                w_byte        = '0;
                w_partial_new = {i_class.sym, 2'b00};
                w_have_byte   = 1'b0;
            end
            2'd1: begin
                w_byte        = r_partial | {6'd0, i_class.sym[5:4]};
                w_partial_new = {i_class.sym[3:0], 4'd0};
            end
            2'd2: begin
                w_byte        = r_partial | {4'd0, i_class.sym[5:2]};
                w_partial_new = {i_class.sym[1:0], 6'd0};
            end
            default: begin
                w_byte        = r_partial | {2'd0, i_class.sym};
                w_partial_new = '0;
            end
        endcase
        w_lim_max   = CW'(i_max_out);
        w_lim_top   = CW'({COUNT_BITS{1'b1}});
        w_limit     = (w_lim_max < w_lim_top) ? w_lim_max : w_lim_top;
        w_cnt_ext   = CW'(r_bytes_out);
        w_ovf       = (w_cnt_ext >= w_limit);
        w_bytes_inc = r_bytes_out + COUNT_BITS'(1);
        w_inc_ext   = CW'(w_bytes_inc);
        // a non-white character that the state machine acts on
        w_active    = !i_item.end_of_text && (r_err == ST_OK) && !i_class.is_white;
    end

    // Status reported by an end marker
    always_comb begin
        w_end_status = r_err;
        if (r_err == ST_OK) begin
            if (r_phase == PH_NEED_PAD) begin
                w_end_status = ST_BAD_PAD;
            end else if (r_phase == PH_SYMBOLS && r_group_pos != 2'd0) begin
                w_end_status = ST_PARTIAL;
            end
        end
    end

    // Next state
    always_comb begin
        n_group_pos = r_group_pos;
        n_phase     = r_phase;
        n_err       = r_err;
        n_partial   = r_partial;
        n_bytes_out = r_bytes_out;
        if (i_item.end_of_text) begin
            n_group_pos = '0;
            n_phase     = PH_SYMBOLS;
            n_err       = ST_OK;
            n_partial   = '0;
            n_bytes_out = '0;
        end else if (w_active) begin
            unique case (r_phase)
                PH_DONE: n_err = ST_BAD_PAD;
                PH_NEED_PAD: begin
                    if (!i_class.is_pad) begin
                        n_err = ST_BAD_PAD;
                    end else if (r_partial != 8'd0) begin
                        n_err = ST_LEFTOVER;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SYMBOLS: begin
                    if (i_class.is_pad) begin
                        if (r_group_pos == 2'd2) begin
                            n_phase = PH_NEED_PAD;
                        end else if (r_group_pos == 2'd3) begin
                            if (r_partial != 8'd0) begin
                                n_err = ST_LEFTOVER;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_err = ST_BAD_PAD;
                        end
                    end else if (!i_class.is_sym) begin
                        n_err = ST_BAD_CHAR;
                    end else begin
                        n_partial   = w_partial_new;
                        n_group_pos = r_group_pos + 2'd1;
                        if (w_have_byte) begin
                            if (w_ovf) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                n_bytes_out = w_bytes_inc;
                            end
                        end
                    end
                end
                default: n_err = ST_BAD_PAD;
            endcase
        end
    end

    // Result of the step
    always_comb begin
        o_res = '0;
        if (i_item.end_of_text) begin
            o_res.has_result      = 1'b1;
            o_res.item.is_final   = 1'b1;
            o_res.item.status     = w_end_status;
            o_res.item.byte_count = w_cnt_ext[15:0];
        end else if (w_active && r_phase == PH_SYMBOLS && !i_class.is_pad
                     && i_class.is_sym && w_have_byte && !w_ovf) begin
            o_res.has_result      = 1'b1;
            o_res.item.data_byte  = w_byte;
            o_res.item.status     = ST_OK;
            o_res.item.byte_count = w_inc_ext[15:0];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_pos <= '0;
            r_phase     <= PH_SYMBOLS;
            r_err       <= ST_OK;
            r_partial   <= '0;
            r_bytes_out <= '0;
        end else if (i_go) begin
            r_group_pos <= n_group_pos;
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_partial   <= n_partial;
            r_bytes_out <= n_bytes_out;
        end
    end

    // An end marker starts a fresh message
    `B64SD_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_go && i_item.end_of_text,
        r_bytes_out == '0 && r_err == ST_OK && r_group_pos == 2'd0, "state not cleared")
    // The first error stays until the end marker
    `B64SD_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n,
        i_go && !i_item.end_of_text && r_err != ST_OK,
        r_err == $past(r_err), "error code changed")
    // Every data item advances the byte count by one
    `B64SD_ASSERT_NEXT(a_count_step, i_clk, i_rst_n,
        i_go && o_res.has_result && !o_res.item.is_final,
        r_bytes_out == $past(w_bytes_inc), "byte count out of step")

endmodule

### sv/base64_strict_decoder_top.sv
// Strict base64 decoder: one character item in, zero or one result item out.
// Uses the handshake on both channels:
//   input  : i_in_valid / o_in_stall, payload i_in_item (char_code, end_of_text)
//   output : o_out_valid / i_out_stall, payload o_out_item
//   config : i_cfg_we / i_cfg_data writes max_output_bytes (reset 65535)
// An item is moved at a clock edge with valid high and stall low.
// Each decoded byte gives a data item; the end marker gives a final item
// with the status and the byte count, and the message state is cleared.
// Whitespace, padding, the first symbol of a group and characters after an
// error give no result.
// An accepted item is held in the input register; when it steps, its result
// is written to the output register.
// Throughput: one item per cycle while o_in_stall is low; the state update is
// a single step of lookup, shift and count compare between the two registers.
// A waiting result stalls only items that produce a result; items without
// one keep flowing. With the output stalled and a held item that makes a
// result, o_in_stall rises. Synchronous reset clears the message state and
// the registers' valid flags and sets the capacity to 65535.
`include "base64_strict_decoder_top_assert.svh"

module base64_strict_decoder_top
    import b64sd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_max_out;

    t_char_class w_class;
    t_step_res   w_res;
    logic        w_go;

    // Character lookup
    b64sd_classify u_classify (
        .i_char_code (r_in.char_code),
        .o_class     (w_class)
    );

    // Decoder state and step
    b64sd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_item    (r_in),
        .i_class   (w_class),
        .i_max_out (r_max_out),
        .o_res     (w_res)
    );

    // Step when the held item either makes no result or finds room
    assign w_go       = r_in_valid && (!w_res.has_result || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res.has_result) begin
            r_out <= w_res.item;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out <= MAX_OUT_RESET;
        end else if (i_cfg_we) begin
            r_max_out <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A step with a result fills the output register
    `B64SD_ASSERT_NEXT(a_res_lands, i_clk, i_rst_n, w_go && w_res.has_result,
        r_out_valid, "result lost")
    // A held item that cannot step stays in place
    `B64SD_ASSERT_NEXT(a_in_holds, i_clk, i_rst_n, r_in_valid && !w_go,
        r_in_valid && r_in == $past(r_in), "held item changed")
    // A stepping item never overwrites a waiting result
    `B64SD_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n,
        w_go && w_res.has_result && r_out_valid, !i_out_stall, "result overwritten")

endmodule
